>>> design/rspe_pkg.sv
// Shared constants for the private exponent recovery block.
// No dependencies; imported by the top level.
package rspe_pkg;

	localparam int unsigned STATUS_BITS = 2;

	typedef logic [STATUS_BITS-1:0] status_t;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_NO_FACTOR  = 2'd1;
	localparam status_t ST_NO_INVERSE = 2'd2;

endpackage

>>> design/rspe_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// No dependencies.
module rspe_div #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         fin,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          fin_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign fin = fin_q;
	assign quo = quo_q;
	assign rem = rem_q;

endmodule

>>> design/rsa_private_exponent_recovery.sv
// Recovers p, q, lambda and d from a small RSA modulus and public exponent.
// Depends on rspe_pkg and rspe_div.
// Each division is issued to the shared divider with go and its result is used once fin
// returns. An item takes one division per trial divisor and per gcd step, then one to
// form lambda and one to reduce the exponent, and per extended Euclid step a division,
// a multiply and a subtract. One item at a time; busy is high throughout. The result
// shows for one cycle with done; the receiver cannot stall.
// Reset (arst_n low) returns the sequencer to idle and drops busy and done.
module rsa_private_exponent_recovery #(
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [WORD_BITS-1:0]    modulus,
	input  logic [WORD_BITS-1:0]    public_exponent,
	output logic                    done,
	output logic [WORD_BITS-1:0]    private_exponent,
	output logic [WORD_BITS-1:0]    factor_small,
	output logic [WORD_BITS-1:0]    factor_large,
	output logic [WORD_BITS-1:0]    carmichael_value,
	output rspe_pkg::status_t       status
);
	import rspe_pkg::*;

	localparam int unsigned W = WORD_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_TRIAL, S_GCD, S_LAMD, S_LAMM, S_EMOD, S_EUD, S_EUM, S_EUS
	} state_t;

	state_t          state_q;
	logic            go_q;
	logic [W-1:0]    da_q;
	logic [W-1:0]    db_q;
	logic            div_fin;
	logic [W-1:0]    div_quo;
	logic [W-1:0]    div_rem;

	logic [W-1:0]    n_q;
	logic [W-1:0]    e_q;
	logic [W-1:0]    t_q;
	logic [W-1:0]    p_q;
	logic [W-1:0]    qf_q;
	logic [W-1:0]    lam_q;
	logic [W-1:0]    b_q;
	logic [W-1:0]    qt_q;
	logic [W-1:0]    r_q;
	logic signed [W:0]     t0_q;
	logic signed [W:0]     t1_q;
	logic signed [W:0]     prod_q;
	logic signed [W:0]     tn;
	logic [W:0]            dfix;

	logic            done_q;
	logic [W-1:0]    d_out_q;
	logic [W-1:0]    p_out_q;
	logic [W-1:0]    q_out_q;
	logic [W-1:0]    l_out_q;
	status_t         st_out_q;

	// Shared divider.
	rspe_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (da_q),
		.divisor  (db_q),
		.fin      (div_fin),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Next Bezout coefficient and its reduction into 0..lambda-1.
	assign tn   = t0_q - prod_q;
	assign dfix = t1_q[W] ? (t1_q + $signed({1'b0, lam_q})) : t1_q;

	// Sequencer with its working and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			go_q     <= 1'b0;
			done_q   <= 1'b0;
			da_q     <= '0;
			db_q     <= '0;
			n_q      <= '0;
			e_q      <= '0;
			t_q      <= '0;
			p_q      <= '0;
			qf_q     <= '0;
			lam_q    <= '0;
			b_q      <= '0;
			qt_q     <= '0;
			r_q      <= '0;
			t0_q     <= '0;
			t1_q     <= '0;
			prod_q   <= '0;
			d_out_q  <= '0;
			p_out_q  <= '0;
			q_out_q  <= '0;
			l_out_q  <= '0;
			st_out_q <= ST_OK;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q     <= modulus;
						e_q     <= public_exponent;
						t_q     <= W'(2);
						da_q    <= modulus;
						db_q    <= W'(2);
						go_q    <= 1'b1;
						state_q <= S_TRIAL;
					end
				end
				S_TRIAL: begin
					if (div_fin) begin
						if (t_q > div_quo) begin
							d_out_q  <= '0;
							p_out_q  <= '0;
							q_out_q  <= '0;
							l_out_q  <= '0;
							st_out_q <= ST_NO_FACTOR;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (div_rem == '0) begin
							p_q     <= t_q;
							qf_q    <= div_quo;
							da_q    <= t_q - 1'b1;
							db_q    <= div_quo - 1'b1;
							go_q    <= 1'b1;
							state_q <= S_GCD;
						end else begin
							t_q  <= t_q + 1'b1;
							da_q <= n_q;
							db_q <= t_q + 1'b1;
							go_q <= 1'b1;
						end
					end
				end
				S_GCD: begin
					// Euclid on p-1 and q-1; the last nonzero divisor is the gcd.
					if (div_fin) begin
						if (div_rem == '0) begin
							da_q    <= p_q - 1'b1;
							db_q    <= db_q;
							go_q    <= 1'b1;
							state_q <= S_LAMD;
						end else begin
							da_q <= db_q;
							db_q <= div_rem;
							go_q <= 1'b1;
						end
					end
				end
				S_LAMD: begin
					if (div_fin) begin
						lam_q   <= W'(div_quo * (qf_q - 1'b1));
						state_q <= S_LAMM;
					end
				end
				S_LAMM: begin
					if (lam_q <= W'(1)) begin
						d_out_q  <= '0;
						p_out_q  <= p_q;
						q_out_q  <= qf_q;
						l_out_q  <= lam_q;
						st_out_q <= ST_NO_INVERSE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						da_q    <= e_q;
						db_q    <= lam_q;
						go_q    <= 1'b1;
						state_q <= S_EMOD;
					end
				end
				S_EMOD: begin
					if (div_fin) begin
						t0_q <= '0;
						t1_q <= (W+1)'(1);
						b_q  <= div_rem;
						if (div_rem == '0) begin
							d_out_q  <= '0;
							p_out_q  <= p_q;
							q_out_q  <= qf_q;
							l_out_q  <= lam_q;
							st_out_q <= ST_NO_INVERSE;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							da_q    <= lam_q;
							db_q    <= div_rem;
							go_q    <= 1'b1;
							state_q <= S_EUD;
						end
					end
				end
				S_EUD: begin
					if (div_fin) begin
						qt_q    <= div_quo;
						r_q     <= div_rem;
						state_q <= S_EUM;
					end
				end
				S_EUM: begin
					// Only the low W+1 bits matter, since the true coefficient fits there.
					prod_q  <= (W+1)'($signed({1'b0, qt_q}) * t1_q);
					state_q <= S_EUS;
				end
				S_EUS: begin
					// Advance one extended Euclid step.
					t0_q <= t1_q;
					t1_q <= tn;
					b_q  <= r_q;
					if (r_q == '0) begin
						p_out_q <= p_q;
						q_out_q <= qf_q;
						l_out_q <= lam_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (b_q == W'(1)) begin
							d_out_q  <= dfix[W-1:0];
							st_out_q <= ST_OK;
						end else begin
							d_out_q  <= '0;
							st_out_q <= ST_NO_INVERSE;
						end
					end else begin
						da_q    <= b_q;
						db_q    <= r_q;
						go_q    <= 1'b1;
						state_q <= S_EUD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign private_exponent = d_out_q;
	assign factor_small     = p_out_q;
	assign factor_large     = q_out_q;
	assign carmichael_value = l_out_q;
	assign status           = st_out_q;

endmodule

>>> dv/rsa_private_exponent_recovery_tb.sv
// Self-checking testbench for rsa_private_exponent_recovery: commands go in by start/busy,
// results come back on done and are compared with a predictor of the key recovery.
// Depends on rspe_pkg and the block's RTL.
module rsa_private_exponent_recovery_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rspe_pkg::*;

	typedef struct packed {
		logic [31:0] modulus;
		logic [31:0] exponent;
	} key_request_t;

	typedef struct packed {
		logic [31:0] private_exponent;
		logic [31:0] factor_small;
		logic [31:0] factor_large;
		logic [31:0] carmichael_value;
		status_t     status;
	} key_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] modulus = '0;
	logic [31:0] public_exponent = '0;
	logic        busy;
	logic        done;
	logic [31:0] private_exponent;
	logic [31:0] factor_small;
	logic [31:0] factor_large;
	logic [31:0] carmichael_value;
	status_t     status;

	key_request_t pending_requests[$];
	key_answer_t  awaited_answers[$];
	int unsigned  error_count = 0;
	int unsigned  answers_seen = 0;
	int unsigned  ok_seen = 0;
	int unsigned  cycle_count = 0;
	int unsigned  burst_left = 0;
	int unsigned  gap_left = 0;
	bit           stimulus_loaded = 1'b0;

	rsa_private_exponent_recovery uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.modulus(modulus),
		.public_exponent(public_exponent),
		.done(done),
		.private_exponent(private_exponent),
		.factor_small(factor_small),
		.factor_large(factor_large),
		.carmichael_value(carmichael_value),
		.status(status)
	);

	always #5 clk = ~clk;

	// Factor the modulus, form lambda and invert the exponent modulo lambda.
	function automatic key_answer_t recover_keys(logic [31:0] n_in, logic [31:0] e_in);
		longint unsigned n, e, divisor, p, q, ga, gb, gr, lam;
		longint unsigned ea, eb, coef_old, coef_new, quot, rem, sub, coef_next;
		bit found;
		key_answer_t answer;
		n = n_in;
		e = e_in;
		found = 1'b0;
		answer = '0;
		answer.status = ST_NO_FACTOR;
		divisor = 2;
		while (divisor <= n / divisor) begin
			if (n % divisor == 0) begin
				found = 1'b1;
				break;
			end
			divisor++;
		end
		if (found) begin
			p = divisor;
			q = n / p;
			ga = p - 1;
			gb = q - 1;
			while (gb != 0) begin
				gr = ga % gb;
				ga = gb;
				gb = gr;
			end
			lam = ((p - 1) / ga) * (q - 1);
			answer.factor_small = p[31:0];
			answer.factor_large = q[31:0];
			answer.carmichael_value = lam[31:0];
			answer.status = ST_NO_INVERSE;
			if (lam > 1) begin
				// Extended Euclid, tracking only the exponent's coefficient.
				ea = lam;
				eb = e % lam;
				coef_old = 0;
				coef_new = 1;
				while (eb != 0) begin
					quot = ea / eb;
					rem = ea % eb;
					sub = ((quot % lam) * coef_new) % lam;
					coef_next = (coef_old >= sub) ? coef_old - sub : coef_old + (lam - sub);
					ea = eb;
					eb = rem;
					coef_old = coef_new;
					coef_new = coef_next;
				end
				if (ea == 1) begin
					answer.private_exponent = coef_old[31:0];
					answer.status = ST_OK;
				end
			end
		end
		return answer;
	endfunction

	// Command driver: bursts of beats separated by random gaps.
	always @(posedge clk) begin
		key_request_t req;
		logic next_start;
		next_start = start;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (start && !busy) begin
				awaited_answers = {awaited_answers, recover_keys(modulus, public_exponent)};
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_requests.size() > 0) begin
					req = pending_requests.pop_front();
					modulus <= req.modulus;
					public_exponent <= req.exponent;
					next_start = 1'b1;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 6);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
		start <= next_start;
	end

	// Result monitor: every done beat must match the oldest expectation.
	always @(posedge clk) begin
		key_answer_t exp_ans;
		int unsigned bad;
		bad = 0;
		if (arst_n && done) begin
			answers_seen <= answers_seen + 1;
			if (awaited_answers.size() == 0) begin
				$error("result beat with nothing expected");
				bad++;
			end else begin
				exp_ans = awaited_answers.pop_front();
				if (exp_ans.status == ST_OK)
					ok_seen <= ok_seen + 1;
				if (private_exponent !== exp_ans.private_exponent) begin
					$error("private_exponent: expected %0d, got %0d",
						exp_ans.private_exponent, private_exponent);
					bad++;
				end
				if (factor_small !== exp_ans.factor_small) begin
					$error("factor_small: expected %0d, got %0d",
						exp_ans.factor_small, factor_small);
					bad++;
				end
				if (factor_large !== exp_ans.factor_large) begin
					$error("factor_large: expected %0d, got %0d",
						exp_ans.factor_large, factor_large);
					bad++;
				end
				if (carmichael_value !== exp_ans.carmichael_value) begin
					$error("carmichael_value: expected %0d, got %0d",
						exp_ans.carmichael_value, carmichael_value);
					bad++;
				end
				if (status !== exp_ans.status) begin
					$error("status: expected %0d, got %0d", exp_ans.status, status);
					bad++;
				end
			end
			if (bad != 0)
				error_count <= error_count + bad;
		end
	end

	// Watchdog against a hung sequencer.
	always @(posedge clk) begin
		if (cycle_count > 6000000) begin
			$display("timeout with %0d results outstanding", awaited_answers.size());
			$display("rsa_private_exponent_recovery regression: fail");
			$finish;
		end
	end

	task automatic queue_request(logic [31:0] n, logic [31:0] e);
		key_request_t req;
		req.modulus = n;
		req.exponent = e;
		pending_requests = {pending_requests, req};
	endtask

	initial begin
		int unsigned small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
			47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
		int unsigned p, q_high, pick;
		logic [31:0] e;

		// Directed corner cases: tiny and prime moduli, lambda of one, exponents
		// that share a factor with lambda, and the word extremes.
		queue_request(32'd0, 32'd3);
		queue_request(32'd1, 32'd3);
		queue_request(32'd2, 32'd3);
		queue_request(32'd3, 32'd3);
		queue_request(32'd4, 32'd3);
		queue_request(32'd6, 32'd1);
		queue_request(32'd9, 32'd5);
		queue_request(32'd15, 32'd3);
		queue_request(32'd15, 32'd7);
		queue_request(32'd25, 32'd3);
		queue_request(32'd3233, 32'd17);
		queue_request(32'd3233, 32'd0);
		queue_request(32'd3233, 32'd780);
		queue_request(32'd3233, 32'hFFFF_FFFF);
		queue_request(32'd65521, 32'd65537);
		queue_request(32'hFFFF_FFFF, 32'd65537);
		queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_request(32'd4294967294, 32'h8000_0001);

		// Random part: mostly a small prime times a random cofactor no smaller than it,
		// plus small noise moduli that may include primes.
		repeat (100) begin
			pick = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: e = 32'd65537;
				1: e = 32'd3;
				default: e = $urandom();
			endcase
			if (pick < 7) begin
				p = small_primes[$urandom_range(0, small_primes.size() - 1)];
				q_high = 32'hFFFF_FFFF / p;
				queue_request(p * $urandom_range(p, q_high), e);
			end else begin
				queue_request($urandom_range(0, 65535), e);
			end
		end
		stimulus_loaded = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_requests.size() == 0 && !start && awaited_answers.size() == 0);
		repeat (200) @(posedge clk);
		$display("Checked %0d results (%0d with an inverse found) against the predictor.",
			answers_seen, ok_seen);
		if (error_count == 0 && awaited_answers.size() == 0)
			$display("rsa_private_exponent_recovery regression: pass");
		else
			$display("rsa_private_exponent_recovery regression: fail");
		$finish;
	end
endmodule

>>> files.f
design/rspe_pkg.sv
design/rspe_div.sv
design/rsa_private_exponent_recovery.sv
dv/rsa_private_exponent_recovery_tb.sv
